// ----- sv/rppo_pkg.sv -----
// ----------------------------------------------------------------------------
// rppo_pkg: shared types and constants of the RGB pixel point-op unit
// Pixel layouts, operation codes, register indexes and the fixed-point
// reciprocal constants used by the arithmetic pipeline.
// ----------------------------------------------------------------------------
package rppo_pkg;

  // pixel byte order: blue in the low byte
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // input word: first image pixel low, second image pixel high
  typedef struct packed {
    pix_t other;
    pix_t src;
  } in_word_t;

  // channel positions inside a pix_t viewed as [2:0][7:0]
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;
  localparam int NUM_CH   = 3;

  // operation codes
  typedef enum logic [3:0] {
    MODE_RED   = 4'd0,
    MODE_GREEN = 4'd1,
    MODE_BLUE  = 4'd2,
    MODE_GREY  = 4'd3,
    MODE_BLEND = 4'd4,
    MODE_DIFF  = 4'd5,
    MODE_MUL   = 4'd6,
    MODE_MIN   = 4'd7,
    MODE_MAX   = 4'd8,
    MODE_SAT   = 4'd9
  } mode_e;

  // register map (index is paddr[2])
  localparam int   CFG_AW        = 3;
  localparam logic REG_OP_MODE   = 1'b0;
  localparam logic REG_BLEND_PCT = 1'b1;

  localparam int         PCT_W     = 7;
  localparam logic [6:0] PCT_FULL  = 7'd100;
  localparam logic [6:0] PCT_RESET = 7'd50;

  // live configuration seen by the datapath (percent already limited to 100)
  typedef struct packed {
    mode_e      mode;
    logic [6:0] pct;
  } cfg_t;

  // x/100 for x <= 25500: (x * 41944) >> 22
  localparam logic [15:0] K100    = 16'd41944;
  localparam int          K100_SH = 22;
  // x/1000 for x <= 255000: (x * 268436) >> 28
  localparam logic [18:0] K1000    = 19'd268436;
  localparam int          K1000_SH = 28;

  // saturation divider
  localparam int SUM_W      = 10;
  localparam int NUM_W      = 18;
  localparam int Q_W        = 8;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;

  // word carried alongside the divider
  typedef struct packed {
    pix_t pix;
    logic sat;
  } side_t;

endpackage

// ----- sv/rgb_pixel_point_op_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_pixel_point_op_unit: per-pixel RGB point operations
// Top level: configuration registers, arithmetic front end, saturation
// divider and output buffer.
// ----------------------------------------------------------------------------
// One pixel word (first image in the low 24 bits, second image in the high
// 24 bits) is taken per clock and one result pixel comes out per word, in
// order. Throughput is one word per clock: two arithmetic stages, a
// four-stage restoring divider for saturation mode (two quotient bits per
// stage), and an output register with a skid register, so s_axis_tready
// only drops after the output has been stalled long enough to fill the
// skid. op_mode selects red, green or blue only, grey, blend, weighted
// difference, multiply, min, max or saturation (other codes give black);
// blend_percent (limited to 100) weights the first image.
// Change the registers only while no words are in flight.
// ----------------------------------------------------------------------------
module rgb_pixel_point_op_unit (
  input  logic                        clk,
  input  logic                        rst,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rppo_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: src_blue, src_green, src_red, other_blue, other_green, other_red
  input  logic [47:0]                 s_axis_tdata,
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: out_blue, out_green, out_red
  output logic [23:0]                 m_axis_tdata
);
  import rppo_pkg::*;

  cfg_t             cfg;
  logic             en;
  logic             a_valid;
  side_t            a_side;
  logic [NUM_W-1:0] a_num;
  logic [SUM_W-1:0] a_den;
  logic             d_valid;
  side_t            d_side;
  logic [Q_W-1:0]   d_quo;
  pix_t             m_pix;

  rppo_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rppo_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_word   (in_word_t'(s_axis_tdata)),
    .cfg       (cfg),
    .out_valid (a_valid),
    .side      (a_side),
    .num       (a_num),
    .den       (a_den)
  );

  rppo_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .in_side   (a_side),
    .num       (a_num),
    .den       (a_den),
    .out_valid (d_valid),
    .out_side  (d_side),
    .quo       (d_quo)
  );

  rppo_out u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_side  (d_side),
    .quo      (d_quo),
    .en       (en),
    .m_valid  (m_axis_tvalid),
    .m_pix    (m_pix),
    .m_ready  (m_axis_tready)
  );

  assign s_axis_tready = en;
  assign m_axis_tdata  = m_pix;

endmodule

// ----- sv/rppo_cfg.sv -----
// ----------------------------------------------------------------------------
// rppo_cfg: configuration registers
// APB-style register file holding op_mode and blend_percent.
// ----------------------------------------------------------------------------
module rppo_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rppo_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rppo_pkg::cfg_t             cfg
);
  import rppo_pkg::*;

  logic [3:0]       op_mode;
  logic [PCT_W-1:0] blend_percent;
  logic [PCT_W-1:0] pct_eff;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode       <= 4'(MODE_GREY);
      blend_percent <= PCT_RESET;
      pct_eff       <= PCT_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_OP_MODE: begin
          op_mode <= pwdata[3:0];
        end
        REG_BLEND_PCT: begin
          blend_percent <= pwdata[PCT_W-1:0];
          pct_eff       <= (pwdata[PCT_W-1:0] > PCT_FULL) ? PCT_FULL : pwdata[PCT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_OP_MODE:   prdata = {28'd0, op_mode};
      REG_BLEND_PCT: prdata = {25'd0, blend_percent};
      default:       prdata = 32'd0;
    endcase
  end

  assign cfg.mode = mode_e'(op_mode);
  assign cfg.pct  = pct_eff;

endmodule

// ----- sv/rppo_arith.sv -----
// ----------------------------------------------------------------------------
// rppo_arith: front two pipeline stages
// Stage 1 forms the products, grey weighted sum, channel min/max and the
// saturation sum/min. Stage 2 scales by reciprocals, selects the per-channel
// result and sets up the saturation dividend and divisor.
// ----------------------------------------------------------------------------
module rppo_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  rppo_pkg::in_word_t            in_word,
  input  rppo_pkg::cfg_t                cfg,
  output logic                          out_valid,
  output rppo_pkg::side_t               side,
  output logic [rppo_pkg::NUM_W-1:0]    num,
  output logic [rppo_pkg::SUM_W-1:0]    den
);
  import rppo_pkg::*;

  logic [NUM_CH-1:0][7:0] s_ch;
  logic [NUM_CH-1:0][7:0] o_ch;
  logic [PCT_W-1:0]       q_pct;

  // stage 1 registers
  logic                    v1;
  mode_e                   mode1;
  logic [NUM_CH-1:0][7:0]  s1;
  logic [NUM_CH-1:0][7:0]  mn1;
  logic [NUM_CH-1:0][7:0]  mx1;
  logic [NUM_CH-1:0][14:0] ps1;
  logic [NUM_CH-1:0][14:0] qo1;
  logic [NUM_CH-1:0][15:0] so1;
  logic [17:0]             gsum1;
  logic [SUM_W-1:0]        sum1;
  logic [7:0]              smin1;

  // stage 2 combinational
  logic [NUM_CH-1:0][7:0]  res_ch;
  logic [36:0]             gprod;
  logic [7:0]              grey_q;
  logic [SUM_W-1:0]        d_sat;
  logic [7:0]              min_gb;

  // stage 2 registers
  logic                    v2;
  side_t                   side2;
  logic [NUM_W-1:0]        num2;
  logic [SUM_W-1:0]        den2;

  assign s_ch  = in_word.src;
  assign o_ch  = in_word.other;
  assign q_pct = PCT_FULL - cfg.pct;
  assign min_gb = (s_ch[CH_BLUE] < s_ch[CH_GREEN]) ? s_ch[CH_BLUE] : s_ch[CH_GREEN];

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= cfg.mode;
      s1    <= s_ch;
      for (int c = 0; c < NUM_CH; c++) begin
        ps1[c] <= 15'(cfg.pct) * 15'(s_ch[c]);
        qo1[c] <= 15'(q_pct) * 15'(o_ch[c]);
        so1[c] <= 16'(s_ch[c]) * 16'(o_ch[c]);
        mn1[c] <= (s_ch[c] < o_ch[c]) ? s_ch[c] : o_ch[c];
        mx1[c] <= (s_ch[c] > o_ch[c]) ? s_ch[c] : o_ch[c];
      end
      gsum1 <= 18'(s_ch[CH_RED]) * 18'd299 + 18'(s_ch[CH_GREEN]) * 18'd587
             + 18'(s_ch[CH_BLUE]) * 18'd114;
      sum1  <= 10'(s_ch[CH_RED]) + 10'(s_ch[CH_GREEN]) + 10'(s_ch[CH_BLUE]);
      smin1 <= (s_ch[CH_RED] < min_gb) ? s_ch[CH_RED] : min_gb;
    end
  end

  // grey: divide weighted sum by 1000
  assign gprod  = 37'(gsum1) * 37'(K1000);
  assign grey_q = gprod[K1000_SH+7:K1000_SH];

  // saturation: sum - 3*min never underflows
  assign d_sat = sum1 - ({2'b00, smin1} + {1'b0, smin1, 1'b0});

  // per-channel result select
  always_comb begin
    logic [15:0] x;
    logic [31:0] prod;
    logic [7:0]  quo;
    logic        neg;
    for (int c = 0; c < NUM_CH; c++) begin
      neg  = (ps1[c] <= qo1[c]);
      x    = (mode1 == MODE_DIFF) ? (16'(ps1[c]) - 16'(qo1[c]))
                                  : (16'(ps1[c]) + 16'(qo1[c]));
      prod = 32'(x) * 32'(K100);
      quo  = prod[K100_SH+7:K100_SH];
      unique case (mode1)
        MODE_RED:   res_ch[c] = (c == CH_RED)   ? s1[c] : 8'd0;
        MODE_GREEN: res_ch[c] = (c == CH_GREEN) ? s1[c] : 8'd0;
        MODE_BLUE:  res_ch[c] = (c == CH_BLUE)  ? s1[c] : 8'd0;
        MODE_GREY:  res_ch[c] = grey_q;
        MODE_BLEND: res_ch[c] = quo;
        MODE_DIFF:  res_ch[c] = neg ? 8'd0 : quo;
        MODE_MUL:   res_ch[c] = (|so1[c][15:8]) ? 8'hFF : so1[c][7:0];
        MODE_MIN:   res_ch[c] = mn1[c];
        MODE_MAX:   res_ch[c] = mx1[c];
        default:    res_ch[c] = 8'd0;
      endcase
    end
  end

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  // stage 2 payload; a black pixel divides 0 by 1
  always_ff @(posedge clk) begin
    if (en) begin
      side2.pix <= res_ch;
      side2.sat <= (mode1 == MODE_SAT);
      num2      <= {d_sat, 8'd0} - NUM_W'(d_sat);
      den2      <= (sum1 == '0) ? SUM_W'(1) : sum1;
    end
  end

  assign out_valid = v2;
  assign side      = side2;
  assign num       = num2;
  assign den       = den2;

endmodule

// ----- sv/rppo_div.sv -----
// ----------------------------------------------------------------------------
// rppo_div: pipelined restoring divider
// Produces an 8-bit quotient, two quotient bits per stage. The dividend is
// known to be below 256 times the divisor. A side word travels along.
// ----------------------------------------------------------------------------
module rppo_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  rppo_pkg::side_t            in_side,
  input  logic [rppo_pkg::NUM_W-1:0] num,
  input  logic [rppo_pkg::SUM_W-1:0] den,
  output logic                       out_valid,
  output rppo_pkg::side_t            out_side,
  output logic [rppo_pkg::Q_W-1:0]   quo
);
  import rppo_pkg::*;

  logic             vld  [DIV_STAGES];
  side_t            sd   [DIV_STAGES];
  logic [NUM_W-1:0] rem  [DIV_STAGES];
  logic [SUM_W-1:0] dv   [DIV_STAGES];
  logic [Q_W-1:0]   qr   [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int TOP_BIT = Q_W - 1 - j * DIV_STEPS;

    logic             v_in;
    side_t            sd_in;
    logic [NUM_W-1:0] rem_in;
    logic [SUM_W-1:0] dv_in;
    logic [Q_W-1:0]   q_in;
    logic [NUM_W-1:0] rem_nx;
    logic [Q_W-1:0]   q_nx;

    if (j == 0) begin : g_first
      assign v_in   = in_valid;
      assign sd_in  = in_side;
      assign rem_in = num;
      assign dv_in  = den;
      assign q_in   = '0;
    end else begin : g_next
      assign v_in   = vld[j-1];
      assign sd_in  = sd[j-1];
      assign rem_in = rem[j-1];
      assign dv_in  = dv[j-1];
      assign q_in   = qr[j-1];
    end

    // two compare/subtract steps
    always_comb begin
      logic [NUM_W-1:0] trial;
      rem_nx = rem_in;
      q_nx   = q_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
        trial = NUM_W'(dv_in) << (TOP_BIT - i);
        if (rem_nx >= trial) begin
          rem_nx = rem_nx - trial;
          q_nx   = {q_nx[Q_W-2:0], 1'b1};
        end else begin
          q_nx   = {q_nx[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[j]  <= sd_in;
        rem[j] <= rem_nx;
        dv[j]  <= dv_in;
        qr[j]  <= q_nx;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_side  = sd[DIV_STAGES-1];
  assign quo       = qr[DIV_STAGES-1];

endmodule

// ----- sv/rppo_out.sv -----
// ----------------------------------------------------------------------------
// rppo_out: result select and output buffer
// Picks the saturation quotient or the precomputed pixel, then holds it in
// an output register backed by a skid register so the pipeline keeps moving
// while a word waits downstream, stalling only once the skid register is full.
// ----------------------------------------------------------------------------
module rppo_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  rppo_pkg::side_t          in_side,
  input  logic [rppo_pkg::Q_W-1:0] quo,
  output logic                     en,
  output logic                     m_valid,
  output rppo_pkg::pix_t           m_pix,
  input  logic                     m_ready
);
  import rppo_pkg::*;

  pix_t sel_pix;
  logic out_valid;
  pix_t out_pix;
  logic skid_valid;
  pix_t skid_pix;
  logic load_out;

  assign sel_pix  = in_side.sat ? pix_t'({quo, quo, quo}) : in_side.pix;
  assign en       = ~skid_valid;
  assign load_out = ~out_valid | m_ready;

  // buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // buffer data
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pix <= skid_valid ? skid_pix : sel_pix;
    end else if (!skid_valid) begin
      skid_pix <= sel_pix;
    end
  end

  assign m_valid = out_valid;
  assign m_pix   = out_pix;

endmodule

// ----- sim/rppo_pixel_checker.sv -----
// ----------------------------------------------------------------------------
// rppo_pixel_checker: result checker for the RGB pixel point-op unit
// Follows register writes and reads on the config port, computes the expected
// result pixel for every input word accepted, and compares each output word,
// channel by channel and in order, against the oldest pending expectation.
// ----------------------------------------------------------------------------
module rppo_pixel_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rppo_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [23:0]                 m_axis_tdata,
  output int                          errors,
  output int                          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import rppo_pkg::*;

  // checker's copy of the registers (percent kept raw, as written)
  logic [3:0] op_code;
  logic [6:0] pct_raw;

  pix_t expected_pixels[$];

  // result pixel of one input word under the given settings
  function automatic pix_t point_op(in_word_t w, logic [3:0] code, logic [6:0] pct);
    logic [2:0][7:0] sa;
    logic [2:0][7:0] oa;
    logic [2:0][7:0] ra;
    int unsigned     p;
    int unsigned     s;
    int unsigned     o;
    int unsigned     v;
    int unsigned     pos;
    int unsigned     neg;
    int unsigned     sum;
    int unsigned     mn;
    sa = w.src;
    oa = w.other;
    ra = '0;
    p  = (pct > PCT_FULL) ? PCT_FULL : pct;
    case (code)
      MODE_RED:   ra[CH_RED]   = sa[CH_RED];
      MODE_GREEN: ra[CH_GREEN] = sa[CH_GREEN];
      MODE_BLUE:  ra[CH_BLUE]  = sa[CH_BLUE];
      MODE_GREY: begin
        // luma weights in thousandths, truncated
        v  = (299 * sa[CH_RED] + 587 * sa[CH_GREEN] + 114 * sa[CH_BLUE]) / 1000;
        ra = {3{v[7:0]}};
      end
      MODE_BLEND, MODE_DIFF, MODE_MUL, MODE_MIN, MODE_MAX: begin
        for (int c = 0; c < NUM_CH; c++) begin
          s = sa[c];
          o = oa[c];
          case (code)
            MODE_BLEND: v = (p * s + (100 - p) * o) / 100;
            MODE_DIFF: begin
              pos = p * s;
              neg = (100 - p) * o;
              v   = (pos <= neg) ? 0 : (pos - neg) / 100;
              if (v > 255) v = 255;
            end
            MODE_MUL:   v = (s * o > 255) ? 255 : s * o;
            MODE_MIN:   v = (s < o) ? s : o;
            default:    v = (s > o) ? s : o;
          endcase
          ra[c] = v[7:0];
        end
      end
      MODE_SAT: begin
        sum = sa[CH_RED] + sa[CH_GREEN] + sa[CH_BLUE];
        mn  = (sa[CH_BLUE] < sa[CH_GREEN]) ? sa[CH_BLUE] : sa[CH_GREEN];
        if (sa[CH_RED] < mn) mn = sa[CH_RED];
        // black pixel has no saturation
        v  = (sum == 0) ? 0 : (255 * (sum - 3 * mn)) / sum;
        ra = {3{v[7:0]}};
      end
      default: ra = '0;  // unused codes give black
    endcase
    return pix_t'(ra);
  endfunction

  // channel names for reports, blue first as in the word
  localparam string CH_NAME [NUM_CH] = '{"out_blue", "out_green", "out_red"};

  always @(posedge clk) begin
    logic [2:0][7:0] got;
    logic [2:0][7:0] want;
    logic [31:0]     reg_val;
    if (rst) begin
      expected_pixels.delete();
      errors  = 0;
      pending <= 0;
      op_code = MODE_GREY;
      pct_raw = PCT_RESET;
    end else begin
      // config port: track writes, check read data
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_OP_MODE) op_code = pwdata[3:0];
          else                         pct_raw = pwdata[6:0];
        end else begin
          reg_val = (paddr[2] == REG_OP_MODE) ? {28'd0, op_code} : {25'd0, pct_raw};
          if (prdata !== reg_val) begin
            $display("%0t: register %0d read expected %0d got %0d",
                     $realtime, paddr[2], reg_val, prdata);
            errors++;
          end
        end
      end
      // output word against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected output word, expected none got %h",
                   $realtime, m_axis_tdata);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          for (int c = 0; c < NUM_CH; c++) begin
            if (got[c] !== want[c]) begin
              $display("%0t: %s expected %0d got %0d", $realtime, CH_NAME[c],
                       want[c], got[c]);
              errors++;
            end
          end
        end
      end
      // input word accepted: predict its result
      if (s_axis_tvalid && s_axis_tready)
        expected_pixels.push_back(point_op(in_word_t'(s_axis_tdata), op_code, pct_raw));
      pending <= expected_pixels.size();
    end
  end

endmodule

// ----- sim/tb_rgb_pixel_point_op_unit.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_pixel_point_op_unit: testbench top of the RGB pixel point-op unit
// Drives the config port and the pixel stream: a short directed pass over
// every operation and the corner cases, then random phases, each under its
// own register settings, most with random gaps on the input and random
// stalls on the output. Checking is done by rppo_pixel_checker.
// ----------------------------------------------------------------------------
module tb_rgb_pixel_point_op_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import rppo_pkg::*;

  localparam int         NUM_PHASES   = 16;
  localparam int         QUIET_LIMIT  = 1000;
  localparam logic [3:0] CODE_UNUSED0 = 4'd10;  // first code with no operation
  localparam logic [3:0] CODE_TOP     = 4'd15;

  // register settings of the random phases
  localparam logic [3:0] MODE_PLAN [NUM_PHASES] = '{
    MODE_BLEND, MODE_DIFF, MODE_DIFF, MODE_BLEND, MODE_DIFF, MODE_BLEND, MODE_MUL,
    MODE_MIN, MODE_MAX, MODE_SAT, MODE_RED, MODE_GREEN, MODE_BLUE, MODE_GREY,
    CODE_UNUSED0, MODE_DIFF};
  localparam logic [6:0] PCT_PLAN [6] = '{7'd0, 7'd100, 7'd0, 7'd127, 7'd101, 7'd100};

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [CFG_AW-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // tdata: src_blue, src_green, src_red, other_blue, other_green, other_red
  logic [47:0]       s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // tdata: out_blue, out_green, out_red
  logic [23:0]       m_axis_tdata;

  int         errors;
  int         pending;
  logic       stalls_on  = 1'b0;
  logic [3:0] stall_left = '0;
  int         quiet      = 0;

  always #4 clk = ~clk;

  rgb_pixel_point_op_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rppo_pixel_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending)
  );

  // output stalls: random bursts of deasserted tready, started only while enabled
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1'b1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left    <= 4'($urandom_range(0, 15));
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || rst) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[rgb_pixel_point_op_unit] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one config access; psel stays high for a back-to-back access
  task automatic apb_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // stop the input and wait until every result is out before returning
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // settle, write both registers (junk in unused bits), read them back
  task automatic set_regs(input logic [3:0] code, input logic [6:0] pct);
    drain();
    apb_access(1'b1, CFG_AW'({REG_OP_MODE, 2'b00}), ($urandom & 32'hFFFF_FFF0) | code);
    apb_access(1'b1, CFG_AW'({REG_BLEND_PCT, 2'b00}), ($urandom & 32'hFFFF_FF80) | pct);
    apb_access(1'b0, CFG_AW'({REG_OP_MODE, 2'b00}), '0);
    apb_access(1'b0, CFG_AW'({REG_BLEND_PCT, 2'b00}), '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // present one input word, optionally after a gap, until it is taken
  task automatic send_pixel(input in_word_t w, input logic gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // byte biased toward the ends and small values (multiply below saturation)
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'($urandom_range(0, 15));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t rand_pix();
    pix_t px;
    px.red   = rand_byte();
    px.green = rand_byte();
    px.blue  = rand_byte();
    // equal channels now and then: no saturation, grey stays put
    if ($urandom_range(0, 15) == 0) px = {3{px.red}};
    return px;
  endfunction

  initial begin
    in_word_t   w;
    logic [3:0] code;
    logic [6:0] pct;
    logic       gaps;
    int         n;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings (grey, 50 percent) on the extremes
    send_pixel('0, 1'b0);
    send_pixel('1, 1'b0);
    // every operation once
    for (int m = MODE_RED; m <= MODE_SAT; m++) begin
      set_regs(4'(m), 7'd50);
      send_pixel(in_word_t'(48'h40C07F_FF0180), 1'b0);
    end
    // saturation of a black pixel and of a pure red one
    set_regs(MODE_SAT, 7'd50);
    send_pixel('0, 1'b0);
    send_pixel(in_word_t'(48'h000000_FF0000), 1'b0);
    // percent above 100 limits to 100
    set_regs(MODE_BLEND, 7'd101);
    send_pixel(in_word_t'(48'h123456_C83201), 1'b0);
    set_regs(MODE_DIFF, 7'd127);
    send_pixel('1, 1'b0);
    // difference that goes negative
    set_regs(MODE_DIFF, 7'd0);
    send_pixel(in_word_t'(48'h010101_FFFFFF), 1'b0);
    // multiply just over and just at full scale
    set_regs(MODE_MUL, 7'd50);
    send_pixel(in_word_t'(48'h10110F_101011), 1'b0);
    // codes with no operation
    set_regs(CODE_UNUSED0, 7'd50);
    send_pixel('1, 1'b0);
    set_regs(CODE_TOP, 7'd127);
    send_pixel(in_word_t'(48'hA5A5A5_5A5A5A), 1'b0);

    // random phases; phase 6 and the last two run with no gaps or stalls
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      code = (MODE_PLAN[ph] == CODE_UNUSED0) ?
             4'($urandom_range(CODE_UNUSED0, CODE_TOP)) : MODE_PLAN[ph];
      pct  = (ph < 6) ? PCT_PLAN[ph] : 7'($urandom_range(0, 127));
      gaps = (ph != 6) && (ph < NUM_PHASES - 2);
      set_regs(code, pct);
      stalls_on <= gaps;
      n = $urandom_range(45, 75);
      repeat (n) begin
        w.src   = rand_pix();
        w.other = rand_pix();
        send_pixel(w, gaps);
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("[rgb_pixel_point_op_unit] OK");
    else
      $display("[rgb_pixel_point_op_unit] ERROR");
    $finish;
  end

endmodule
